>>> hdl/char_lcd_4bit_interface_macros.svh
// Assertion macros shared by the character LCD interface modules.
// Needs nothing else; the asserting modules include this header.
`ifndef CHAR_LCD_4BIT_INTERFACE_MACROS_SVH
`define CHAR_LCD_4BIT_INTERFACE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LCD4_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcd4 assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LCD4_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcd4 assertion failed");

`endif

>>> hdl/lcd4_pkg.sv
// Shared types, codes and constant tables for the character LCD interface.
// Used by lcd4_front, lcd4_fifo, lcd4_back and char_lcd_4bit_interface.
package lcd4_pkg;

    // Request codes
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_DATA   = 3'd2;
    localparam logic [2:0] OP_CURSOR = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Fixed command values and waits in microseconds
    localparam logic [7:0]  ROW0_BASE      = 8'h80;
    localparam logic [7:0]  ROW1_BASE      = 8'hC0;
    localparam logic [7:0]  CMD_CLEAR      = 8'h01;
    localparam logic [13:0] CLEAR_WAIT_US  = 14'd2000;
    localparam logic [15:0] POWER_UP_US    = 16'd50000;
    localparam logic [3:0]  INIT_STEPS     = 4'd9;
    localparam logic [9:0]  HOLD_RESET_US  = 10'd20;

    // One queued job: a power-up wait or one byte with its trailing delay
    typedef struct packed {
        logic        power_up;
        logic        rs;
        logic [7:0]  data;
        logic [13:0] extra_us;
        logic        last;
    } lcd4_job_t;

    // Initialisation command list
    function automatic logic [7:0] init_cmd(input logic [3:0] idx);
        logic [7:0] cmd;
        case (idx)
            4'd0:    cmd = 8'h30;
            4'd1:    cmd = 8'h30;
            4'd2:    cmd = 8'h30;
            4'd3:    cmd = 8'h20;
            4'd4:    cmd = 8'h28;
            4'd5:    cmd = 8'h08;
            4'd6:    cmd = 8'h01;
            4'd7:    cmd = 8'h06;
            4'd8:    cmd = 8'h0C;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

    // Delay after each initialisation command
    function automatic logic [13:0] init_wait(input logic [3:0] idx);
        logic [13:0] wait_us;
        case (idx)
            4'd0:    wait_us = 14'd5000;
            4'd1:    wait_us = 14'd1000;
            4'd2:    wait_us = 14'd10000;
            4'd3:    wait_us = 14'd10000;
            4'd4:    wait_us = 14'd1000;
            4'd5:    wait_us = 14'd1000;
            4'd6:    wait_us = 14'd2000;
            4'd7:    wait_us = 14'd1000;
            default: wait_us = 14'd0;
        endcase
        return wait_us;
    endfunction

endpackage

>>> hdl/lcd4_front.sv
// Request front end: accepts requests and turns them into byte jobs.
// Depends on lcd4_pkg; feeds the job queue (lcd4_fifo).
module lcd4_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          op,
    input  logic [7:0]          byte_value,
    input  logic [1:0]          row,
    input  logic [6:0]          column,
    input  logic                fifo_full,
    output logic                push,
    output lcd4_pkg::lcd4_job_t push_job
);

    typedef enum logic {
        ST_IDLE,
        ST_INIT
    } state_t;

    state_t     state_reg;
    logic [3:0] step_reg;
    logic       accept;
    logic [3:0] cmd_idx;

    assign in_ready = (state_reg == ST_IDLE) && !fifo_full;
    assign accept   = in_valid && in_ready;
    assign cmd_idx  = step_reg - 4'd1;

    // Job selection: the init sequencer while it runs, otherwise the decoded request.
    always_comb
    begin
        push     = 1'b0;
        push_job = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                push = !fifo_full;
                if (step_reg == 4'd0)
                begin
                    push_job.power_up = 1'b1;
                end
                else
                begin
                    push_job.data     = lcd4_pkg::init_cmd(cmd_idx);
                    push_job.extra_us = lcd4_pkg::init_wait(cmd_idx);
                    push_job.last     = (step_reg == lcd4_pkg::INIT_STEPS);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    push_job.last = 1'b1;
                    unique case (op)
                        lcd4_pkg::OP_CMD:
                        begin
                            push          = 1'b1;
                            push_job.data = byte_value;
                        end
                        lcd4_pkg::OP_DATA:
                        begin
                            push          = 1'b1;
                            push_job.rs   = 1'b1;
                            push_job.data = byte_value;
                        end
                        lcd4_pkg::OP_CURSOR:
                        begin
                            push = 1'b1;
                            case (row)
                                2'd0:    push_job.data = lcd4_pkg::ROW0_BASE | {1'b0, column};
                                2'd1:    push_job.data = lcd4_pkg::ROW1_BASE | {1'b0, column};
                                default: push_job.data = {1'b0, column};
                            endcase
                        end
                        lcd4_pkg::OP_CLEAR:
                        begin
                            push              = 1'b1;
                            push_job.data     = lcd4_pkg::CMD_CLEAR;
                            push_job.extra_us = lcd4_pkg::CLEAR_WAIT_US;
                        end
                        default:
                        begin
                            // Initialise is handled by the sequencer; unknown codes are dropped.
                            push = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // State and init step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 4'd0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (op == lcd4_pkg::OP_INIT))
                    begin
                        state_reg <= ST_INIT;
                        step_reg  <= 4'd0;
                    end
                end
                ST_INIT:
                begin
                    if (!fifo_full)
                    begin
                        if (step_reg == lcd4_pkg::INIT_STEPS)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            step_reg <= step_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/lcd4_fifo.sv
// Short job queue between the request front end and the pin sequencer.
// Depends on lcd4_pkg and the assertion macros header.
`include "char_lcd_4bit_interface_macros.svh"

module lcd4_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lcd4_pkg::lcd4_job_t push_data,
    input  logic                pop,
    output lcd4_pkg::lcd4_job_t head,
    output logic                empty,
    output logic                full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcd4_pkg::lcd4_job_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push;
    logic                do_pop;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `LCD4_ASSERT_IMP(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `LCD4_ASSERT_NXT(a_pop_only_push_fills, clk, rst_n, empty && !push, empty)

endmodule

>>> hdl/lcd4_back.sv
// Pin sequencer: plays each queued job as timed pin states into the output register.
// Depends on lcd4_pkg and the assertion macros header.
`include "char_lcd_4bit_interface_macros.svh"

module lcd4_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [9:0]          enable_hold_us,
    input  logic                job_empty,
    input  lcd4_pkg::lcd4_job_t job_head,
    output logic                job_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                reg_select,
    output logic [3:0]          nibble,
    output logic                enable,
    output logic [15:0]         hold_us,
    output logic                last
);

    // Phase: 0 high nibble EN high, 1 high nibble EN low,
    //        2 low nibble EN high, 3 low nibble EN low.
    logic [1:0]  phase_reg;
    logic        out_valid_reg;
    logic        load;
    logic        final_state;
    logic        rs_next;
    logic [3:0]  nibble_next;
    logic        enable_next;
    logic [15:0] hold_next;
    logic        last_next;

    logic        rs_reg;
    logic [3:0]  nibble_reg;
    logic        enable_reg;
    logic [15:0] hold_reg;
    logic        last_reg;

    assign load        = !job_empty && (!out_valid_reg || out_ready);
    assign final_state = job_head.power_up || (phase_reg == 2'd3);
    assign job_pop     = load && final_state;

    // Pin state for the current job and phase.
    always_comb
    begin
        if (job_head.power_up)
        begin
            rs_next     = 1'b0;
            nibble_next = 4'd0;
            enable_next = 1'b0;
            hold_next   = lcd4_pkg::POWER_UP_US;
            last_next   = job_head.last;
        end
        else
        begin
            rs_next     = job_head.rs;
            nibble_next = phase_reg[1] ? job_head.data[3:0] : job_head.data[7:4];
            enable_next = !phase_reg[0];
            if (phase_reg == 2'd3)
            begin
                hold_next = 16'(enable_hold_us) + 16'(job_head.extra_us);
            end
            else
            begin
                hold_next = 16'(enable_hold_us);
            end
            last_next   = job_head.last && (phase_reg == 2'd3);
        end
    end

    // Phase counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                phase_reg     <= final_state ? 2'd0 : phase_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rs_reg     <= rs_next;
            nibble_reg <= nibble_next;
            enable_reg <= enable_next;
            hold_reg   <= hold_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign reg_select = rs_reg;
    assign nibble     = nibble_reg;
    assign enable     = enable_reg;
    assign hold_us    = hold_reg;
    assign last       = last_reg;

    `LCD4_ASSERT_NXT(a_phase_holds_on_stall, clk, rst_n, out_valid_reg && !out_ready, $stable(phase_reg))
    `LCD4_ASSERT_IMP(a_power_up_at_phase0, clk, rst_n, !job_empty && job_head.power_up, phase_reg == 2'd0)
    `LCD4_ASSERT_IMP(a_last_has_enable_low, clk, rst_n, out_valid_reg && last_reg, !enable_reg)

endmodule

>>> hdl/char_lcd_4bit_interface.sv
// Top level of the 4-bit character LCD bus driver.
// Depends on lcd4_pkg, lcd4_front, lcd4_fifo and lcd4_back.
//
// Usage:
//   Requests arrive on the in_valid/in_ready channel (op, byte_value, row, column).
//   Each produces a series of pin-state beats on out_valid/out_ready: RS, D7..D4, EN
//   and the hold time in microseconds, with last set on the request's final beat.
//   A byte request gives 4 beats; initialise gives 37; op codes 5 to 7 give none.
//   The first beat of a byte request passes through the job queue and then the output
//   register; an initialise request first enters the init sequencer. Further beats
//   follow one per cycle while out_ready is high, paced by the pin sequencer which
//   emits one pin state per cycle while the receiver takes them.
//   The front end keeps taking requests while the job queue has room, so a stalled
//   receiver holds the current beat in the output register and backs up the queue
//   until in_ready falls. During initialise no new request is taken until all ten
//   jobs are queued.
//   cfg_wr_en writes cfg_wr_data into the enable hold register.
//   Reset empties the queue, drops any pending beat and sets the enable hold to 20 us.
module char_lcd_4bit_interface #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  byte_value,
    input  logic [1:0]  row,
    input  logic [6:0]  column,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic        enable,
    output logic [15:0] hold_us,
    output logic        last
);

    logic [9:0]          enable_hold_reg;
    logic                fifo_full;
    logic                fifo_empty;
    logic                push;
    logic                pop;
    lcd4_pkg::lcd4_job_t push_job;
    lcd4_pkg::lcd4_job_t head_job;

    // Enable hold configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_hold_reg <= lcd4_pkg::HOLD_RESET_US;
        end
        else if (cfg_wr_en)
        begin
            enable_hold_reg <= cfg_wr_data;
        end
    end

    lcd4_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .byte_value (byte_value),
        .row        (row),
        .column     (column),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_job   (push_job)
    );

    lcd4_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .head      (head_job),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    lcd4_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .enable_hold_us (enable_hold_reg),
        .job_empty      (fifo_empty),
        .job_head       (head_job),
        .job_pop        (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reg_select     (reg_select),
        .nibble         (nibble),
        .enable         (enable),
        .hold_us        (hold_us),
        .last           (last)
    );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the 4-bit character LCD bus driver.
// Needs lcd4_pkg and char_lcd_4bit_interface; predicts every pin-state beat in-house.
// Covers requests and hold settings, random idling on both channels and a long receiver stall.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int LONG_STALL    = 400;
    localparam int RANDOM_ITEMS  = 340;
    localparam int RANDOM_PHASES = 7;
    localparam int MAX_PRINTED   = 40;

    // Request codes that the block ignores
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    // Hold settings of interest
    localparam logic [9:0] HOLD_ZERO_US = 10'd0;
    localparam logic [9:0] HOLD_MIN_US  = 10'd1;
    localparam logic [9:0] HOLD_MAX_US  = 10'd1023;

    // Power-up command list and the wait after each command, entry 0 first
    localparam logic [8:0][7:0] POWER_UP_CMDS = {
        8'h0C, 8'h06, 8'h01, 8'h08, 8'h28, 8'h20, 8'h30, 8'h30, 8'h30
    };
    localparam logic [8:0][15:0] POWER_UP_WAITS = {
        16'd0, 16'd1000, 16'd2000, 16'd1000, 16'd1000,
        16'd10000, 16'd10000, 16'd1000, 16'd5000
    };

    // One pin state as the block presents it
    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic        en;
        logic [15:0] hold;
        logic        fin;
    } pin_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [9:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = '0;
    logic [7:0]  byte_value = '0;
    logic [1:0]  row = '0;
    logic [6:0]  column = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        reg_select;
    logic [3:0]  nibble;
    logic        enable;
    logic [15:0] hold_us;
    logic        last;

    pin_state_t  pin_states_due[$];
    pin_state_t  head_state;
    logic [9:0]  hold_setting = lcd4_pkg::HOLD_RESET_US;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int long_stall_cycles = 0;
    int stalls_served = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int beats_checked = 0;
    int requests_sent = 0;
    int requests_ignored = 0;
    int settings_written = 0;

    char_lcd_4bit_interface dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .byte_value  (byte_value),
        .row         (row),
        .column      (column),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .reg_select  (reg_select),
        .nibble      (nibble),
        .enable      (enable),
        .hold_us     (hold_us),
        .last        (last)
    );

    // Free-running clock.
    always #(CLK_HALF_NS) clk = ~clk;

    // Cycle count and the overall time limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Prints one line per mismatch, up to a cap, and counts them all.
    task automatic report(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Returns an idle gap: mostly none or short, occasionally long.
    function automatic int pick_gap(input bit idle_on);
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Queues one expected pin state.
    function automatic void push_pin_state(input logic rs, input logic [3:0] nib,
                                           input logic en, input logic [15:0] hold,
                                           input logic fin);
        pin_state_t s;
        s.rs   = rs;
        s.nib  = nib;
        s.en   = en;
        s.hold = hold;
        s.fin  = fin;
        pin_states_due.push_back(s);
    endfunction

    // A byte is two nibbles, each an enable-high then an enable-low hold;
    // any trailing delay lengthens the final enable-low hold.
    function automatic void push_lcd_byte(input logic rs, input logic [7:0] val,
                                          input logic [15:0] extra, input logic fin);
        logic [15:0] h;
        h = {6'd0, hold_setting};
        push_pin_state(rs, val[7:4], 1'b1, h, 1'b0);
        push_pin_state(rs, val[7:4], 1'b0, h, 1'b0);
        push_pin_state(rs, val[3:0], 1'b1, h, 1'b0);
        push_pin_state(rs, val[3:0], 1'b0, h + extra, fin);
    endfunction

    // Works out every pin state that one accepted request causes.
    function automatic void predict_pin_states(input logic [2:0] req_op,
                                               input logic [7:0] req_byte,
                                               input logic [1:0] req_row,
                                               input logic [6:0] req_col);
        logic [7:0] addr;
        case (req_op)
            lcd4_pkg::OP_INIT:
            begin
                push_pin_state(1'b0, 4'h0, 1'b0, lcd4_pkg::POWER_UP_US, 1'b0);
                for (int i = 0; i < int'(lcd4_pkg::INIT_STEPS); i++)
                    push_lcd_byte(1'b0, POWER_UP_CMDS[i], POWER_UP_WAITS[i],
                                  i == int'(lcd4_pkg::INIT_STEPS) - 1);
            end
            lcd4_pkg::OP_CMD:
                push_lcd_byte(1'b0, req_byte, 16'd0, 1'b1);
            lcd4_pkg::OP_DATA:
                push_lcd_byte(1'b1, req_byte, 16'd0, 1'b1);
            lcd4_pkg::OP_CURSOR:
            begin
                // Rows beyond the second pass the column through as a raw command.
                addr = {1'b0, req_col};
                if (req_row == 2'd0)
                    addr = addr | lcd4_pkg::ROW0_BASE;
                else if (req_row == 2'd1)
                    addr = addr | lcd4_pkg::ROW1_BASE;
                push_lcd_byte(1'b0, addr, 16'd0, 1'b1);
            end
            lcd4_pkg::OP_CLEAR:
                push_lcd_byte(1'b0, lcd4_pkg::CMD_CLEAR,
                              {2'b00, lcd4_pkg::CLEAR_WAIT_US}, 1'b1);
            default:
            begin
            end
        endcase
    endfunction

    // Offers one request beat, waits for it to be taken, then predicts it.
    // On return in_valid is still high; the next send or a drain sets it.
    task automatic send_req(input logic [2:0] req_op, input logic [7:0] req_byte,
                            input logic [1:0] req_row, input logic [6:0] req_col);
        int gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= req_op;
        byte_value <= req_byte;
        row        <= req_row;
        column     <= req_col;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pin_states(req_op, req_byte, req_row, req_col);
        if (req_op inside {lcd4_pkg::OP_INIT, lcd4_pkg::OP_CMD, lcd4_pkg::OP_DATA,
                           lcd4_pkg::OP_CURSOR, lcd4_pkg::OP_CLEAR})
            requests_sent++;
        else
            requests_ignored++;
    endtask

    // Stops offering and waits until every predicted beat has been seen.
    task automatic drain_all();
        in_valid <= 1'b0;
        while (pin_states_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the enable hold register; only called with the block idle.
    task automatic write_hold(input logic [9:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        hold_setting  = val;
        settings_written++;
    endtask

    // Sends one random request; ignored codes do not count.
    task automatic send_random(output bit counted);
        int r;
        logic [2:0] o;
        r = $urandom_range(0, 99);
        if (r < 4)
            o = lcd4_pkg::OP_INIT;
        else if (r < 30)
            o = lcd4_pkg::OP_CMD;
        else if (r < 58)
            o = lcd4_pkg::OP_DATA;
        else if (r < 82)
            o = lcd4_pkg::OP_CURSOR;
        else if (r < 92)
            o = lcd4_pkg::OP_CLEAR;
        else
            o = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        send_req(o, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                 7'($urandom_range(0, 127)));
        counted = o inside {lcd4_pkg::OP_INIT, lcd4_pkg::OP_CMD, lcd4_pkg::OP_DATA,
                            lcd4_pkg::OP_CURSOR, lcd4_pkg::OP_CLEAR};
    endtask

    // Every request kind at the reset hold, all cursor rows and the ignored codes.
    task automatic test_power_up_defaults();
        send_req(lcd4_pkg::OP_INIT, 8'h00, 2'd0, 7'd0);
        send_req(lcd4_pkg::OP_CMD, 8'h38, 2'd1, 7'd3);
        send_req(lcd4_pkg::OP_DATA, 8'h41, 2'd2, 7'd9);
        send_req(lcd4_pkg::OP_CURSOR, 8'h00, 2'd0, 7'd5);
        send_req(lcd4_pkg::OP_CURSOR, 8'h00, 2'd1, 7'd5);
        send_req(lcd4_pkg::OP_CURSOR, 8'h00, 2'd2, 7'd5);
        send_req(lcd4_pkg::OP_CURSOR, 8'h00, 2'd3, 7'd5);
        send_req(lcd4_pkg::OP_CLEAR, 8'hFF, 2'd3, 7'd127);
        send_req(OP_RSVD_FIRST, 8'h12, 2'd0, 7'd1);
        send_req(OP_RSVD_FIRST + 3'd1, 8'h34, 2'd1, 7'd2);
        send_req(OP_RSVD_LAST, 8'h56, 2'd2, 7'd3);
        drain_all();
    endtask

    // Extreme byte and column values.
    task automatic test_field_extremes();
        send_req(lcd4_pkg::OP_CMD, 8'h00, 2'd0, 7'd0);
        send_req(lcd4_pkg::OP_CMD, 8'hFF, 2'd3, 7'd127);
        send_req(lcd4_pkg::OP_DATA, 8'h00, 2'd0, 7'd0);
        send_req(lcd4_pkg::OP_DATA, 8'hFF, 2'd3, 7'd127);
        send_req(lcd4_pkg::OP_CURSOR, 8'h00, 2'd0, 7'd127);
        send_req(lcd4_pkg::OP_CURSOR, 8'hFF, 2'd1, 7'd127);
        send_req(lcd4_pkg::OP_CURSOR, 8'h00, 2'd2, 7'd127);
        send_req(lcd4_pkg::OP_CURSOR, 8'hFF, 2'd3, 7'd0);
        drain_all();
    endtask

    // Largest hold with the longest waits, then zero-length and minimal holds.
    task automatic test_hold_extremes();
        write_hold(HOLD_MAX_US);
        send_req(lcd4_pkg::OP_INIT, 8'h00, 2'd0, 7'd0);
        send_req(lcd4_pkg::OP_CLEAR, 8'h00, 2'd0, 7'd0);
        drain_all();
        write_hold(HOLD_ZERO_US);
        send_req(lcd4_pkg::OP_DATA, 8'h5A, 2'd0, 7'd0);
        drain_all();
        write_hold(HOLD_MIN_US);
        send_req(lcd4_pkg::OP_CMD, 8'hA5, 2'd0, 7'd0);
        drain_all();
    endtask

    // Random requests over several hold settings and idling mixes.
    task automatic test_random_traffic();
        int per_phase;
        int sent;
        bit counted;
        logic [9:0] h;
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       h = HOLD_MAX_US;
                1:       h = HOLD_MIN_US;
                3:       h = lcd4_pkg::HOLD_RESET_US;
                5:       h = HOLD_ZERO_US;
                default: h = 10'($urandom_range(2, 1022));
            endcase
            write_hold(h);
            // One phase runs flat out on both sides.
            tx_idle_on = (p == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
            rx_idle_on = (p == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < ((p == RANDOM_PHASES - 1) ?
                           RANDOM_ITEMS - per_phase * (RANDOM_PHASES - 1) : per_phase))
            begin
                send_random(counted);
                if (counted)
                    sent++;
                // Now and then the sender waits for the block to empty.
                if ($urandom_range(0, 99) < 3)
                    drain_all();
            end
            drain_all();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the job queue fills and in_ready drops; then the sender waits it out.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        long_stall_cycles = LONG_STALL;
        for (int i = 0; i < 16; i++)
            send_req((i % 3 == 0) ? lcd4_pkg::OP_DATA : lcd4_pkg::OP_CMD,
                     8'($urandom_range(0, 255)),
                     2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
        send_req(lcd4_pkg::OP_INIT, 8'h00, 2'd0, 7'd0);
        drain_all();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver: random ready gaps, and a long hold-off when asked for one.
    initial
    begin
        int gap;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (long_stall_cycles > 0)
            begin
                gap = long_stall_cycles;
                long_stall_cycles = 0;
                stalls_served++;
            end
            else if ($urandom_range(0, 99) < 30)
                gap = pick_gap(rx_idle_on);
            else
                gap = 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Checks each output beat against the oldest prediction, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            beats_checked++;
            if (pin_states_due.size() == 0)
                report("pin-state beat with nothing outstanding");
            else
            begin
                head_state = pin_states_due.pop_front();
                if (reg_select !== head_state.rs)
                    report($sformatf("reg_select %b, predicted %b", reg_select, head_state.rs));
                if (nibble !== head_state.nib)
                    report($sformatf("nibble %h, predicted %h", nibble, head_state.nib));
                if (enable !== head_state.en)
                    report($sformatf("enable %b, predicted %b", enable, head_state.en));
                if (hold_us !== head_state.hold)
                    report($sformatf("hold_us %0d, predicted %0d", hold_us, head_state.hold));
                if (last !== head_state.fin)
                    report($sformatf("last %b, predicted %b", last, head_state.fin));
            end
        end
    end

    // Reset, the tests in turn, and the verdict.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up_defaults();
        test_field_extremes();
        test_hold_extremes();
        test_random_traffic();
        test_backpressure();
        drain_all();

        $display("tb: %0d requests and %0d ignored codes sent, %0d pin-state beats checked",
                 requests_sent, requests_ignored, beats_checked);
        $display("tb: %0d hold settings written, %0d long receiver stall(s)",
                 settings_written, stalls_served);
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/lcd4_pkg.sv
hdl/lcd4_front.sv
hdl/lcd4_fifo.sv
hdl/lcd4_back.sv
hdl/char_lcd_4bit_interface.sv
tb/sv/tb.sv
